// File: rtl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and character codes for the movetext cleaner
// payload structs for both channels, the inter-stage struct and byte classes
// ----------------------------------------------------------------------------
package pmc_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DOLAR = 8'h24;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] clean_byte;
		logic       byte_present;
		logic       text_done;
	} result_t;

	// byte leaving stage one toward stage two
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} mid_t;

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

// File: rtl/pmc_stage_one.sv
// ----------------------------------------------------------------------------
// pmc_stage_one: comment, variation and annotation stripper
// drops markup, collapses separator runs into one space, halts at a NUL or a semicolon
// ----------------------------------------------------------------------------
module pmc_stage_one import pmc_pkg::*; #(
	parameter int MAX_NESTING = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  logic [7:0] text_byte,
	output mid_t       mid
);

	localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);
	localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

	logic               in_comment_q, in_comment_d;
	logic               in_variation_q, in_variation_d;
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic               in_annotation_q, in_annotation_d;
	logic               sep_done_q, sep_done_d;
	logic               any_kept_q, any_kept_d;
	logic               halted_q, halted_d;
	logic               is_sep;

	assign is_sep = text_byte inside {CH_LF, CH_VT, CH_TAB, CH_SPACE, CH_BANG, CH_QUEST, CH_CR};

	always_comb begin
		in_comment_d    = in_comment_q;
		in_variation_d  = in_variation_q;
		depth_d         = depth_q;
		in_annotation_d = in_annotation_q;
		sep_done_d      = sep_done_q;
		any_kept_d      = any_kept_q;
		halted_d        = halted_q;
		mid.valid       = 1'b0;
		mid.data        = text_byte;
		if (halted_q) begin
			mid.valid = 1'b0;
		end else if (in_comment_q) begin
			if (text_byte == CH_RBRC) begin
				in_comment_d = 1'b0;
			end
		end else if (text_byte == CH_SEMI || text_byte == CH_NUL) begin
			halted_d = 1'b1;
		end else if (text_byte == CH_LBRC) begin
			in_comment_d = 1'b1;
		end else if (in_variation_q) begin
			if (text_byte == CH_RPAR) begin
				if (depth_q != '0) begin
					depth_d = depth_q - DEPTH_ONE;
				end
				if (depth_q <= DEPTH_ONE) begin
					in_variation_d = 1'b0;
				end
			end else if (text_byte == CH_LPAR) begin
				if (depth_q < DEPTH_MAX) begin
					depth_d = depth_q + DEPTH_ONE;
				end
			end
		end else if (text_byte == CH_LPAR) begin
			in_variation_d = 1'b1;
			depth_d        = DEPTH_ONE;
		end else if (in_annotation_q && is_digit(text_byte)) begin
			mid.valid = 1'b0;
		end else begin
			in_annotation_d = 1'b0;
			if (text_byte == CH_DOLAR) begin
				in_annotation_d = 1'b1;
			end else if (is_sep) begin
				if (!sep_done_q && any_kept_q) begin
					sep_done_d = 1'b1;
					mid.valid  = 1'b1;
					mid.data   = CH_SPACE;
				end
			end else begin
				sep_done_d = 1'b0;
				any_kept_d = 1'b1;
				mid.valid  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q    <= 1'b0;
			in_variation_q  <= 1'b0;
			depth_q         <= '0;
			in_annotation_q <= 1'b0;
			sep_done_q      <= 1'b0;
			any_kept_q      <= 1'b0;
			halted_q        <= 1'b0;
		end else if (step) begin
			if (last) begin
				in_comment_q    <= 1'b0;
				in_variation_q  <= 1'b0;
				depth_q         <= '0;
				in_annotation_q <= 1'b0;
				sep_done_q      <= 1'b0;
				any_kept_q      <= 1'b0;
				halted_q        <= 1'b0;
			end else begin
				in_comment_q    <= in_comment_d;
				in_variation_q  <= in_variation_d;
				depth_q         <= depth_d;
				in_annotation_q <= in_annotation_d;
				sep_done_q      <= sep_done_d;
				any_kept_q      <= any_kept_d;
				halted_q        <= halted_d;
			end
		end
	end

endmodule

// File: rtl/pmc_stage_two.sv
// ----------------------------------------------------------------------------
// pmc_stage_two: move number and dot remover
// drops the first byte, dots and move-number digits, one space per gap
// ----------------------------------------------------------------------------
module pmc_stage_two import pmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       last,
	input  mid_t       mid,
	output logic       present,
	output logic [7:0] fin
);

	logic       started_q;
	logic [7:0] prev_q;
	logic       space_emitted_q, space_emitted_d;

	always_comb begin
		present         = 1'b0;
		fin             = mid.data;
		space_emitted_d = space_emitted_q;
		if (mid.valid && started_q) begin
			if (mid.data == CH_DOT) begin
				present = 1'b0;
			end else if (mid.data == CH_SPACE) begin
				if (prev_q != CH_SPACE && !space_emitted_q) begin
					space_emitted_d = 1'b1;
					present         = 1'b1;
				end
			end else if (is_digit(mid.data) && (prev_q == CH_SPACE || is_digit(prev_q))) begin
				present = 1'b0;
			end else begin
				space_emitted_d = 1'b0;
				present         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q       <= 1'b0;
			prev_q          <= '0;
			space_emitted_q <= 1'b0;
		end else if (step) begin
			if (last) begin
				started_q       <= 1'b0;
				prev_q          <= '0;
				space_emitted_q <= 1'b0;
			end else if (mid.valid) begin
				started_q       <= 1'b1;
				prev_q          <= mid.data;
				space_emitted_q <= space_emitted_d;
			end
		end
	end

endmodule

// File: rtl/pgn_movetext_cleaner.sv
// ----------------------------------------------------------------------------
// pgn_movetext_cleaner: chess movetext cleaner, one byte per transfer
// a kept byte passes the input register and then the result register
// throughput: one input byte per cycle while the result channel does not stall,
//   set by the combinational filter stages between the input register and the result register
// reset: arst_n clears all filter state and both valid flags at once;
//   an end-of-text byte also returns the filters to their reset state
// ----------------------------------------------------------------------------
module pgn_movetext_cleaner import pmc_pkg::*; #(
	parameter int MAX_NESTING = 15
) (
	input  logic    clk,
	input  logic    arst_n,
	// input channel
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	// result channel
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// input register
	logic       item_valid_s1;
	item_t      item_s1;

	// result register
	logic       result_valid_q;
	result_t    result_q;

	// filter datapath
	mid_t       mid;
	logic       present;
	logic [7:0] fin;
	logic       emit;
	logic       advance;
	logic       result_free;

	// a result is produced for a kept byte or for the closing byte
	assign emit        = present || item_s1.end_of_text;
	// the result register can take a new result this cycle
	assign result_free = !result_valid_q || !result_stall;
	// items that make no result never wait on the output side
	assign advance     = item_valid_s1 && (!emit || result_free);
	// the input register refills in the same cycle that it drains
	assign item_stall  = item_valid_s1 && !advance;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	pmc_stage_one #(
		.MAX_NESTING(MAX_NESTING)
	) u_stage_one (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.last      (item_s1.end_of_text),
		.text_byte (item_s1.text_byte),
		.mid       (mid)
	);

	pmc_stage_two u_stage_two (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.last    (item_s1.end_of_text),
		.mid     (mid),
		.present (present),
		.fin     (fin)
	);

	// input register: load on every transfer, drop when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// result register: holds while stalled, otherwise takes the next result or empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q.clean_byte   <= present ? fin : 8'h00;
			result_q.byte_present <= present;
			result_q.text_done    <= item_s1.end_of_text;
		end
	end

	// the input side only stalls while an item sits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> item_valid_s1)
		else $error("input stalled with an empty input register");

	// a result leaving the filters shows up on the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> result_valid_q)
		else $error("filtered result lost");

	// a result without a byte must be the closing one
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_q.byte_present |-> result_q.text_done)
		else $error("empty result that does not close the text");

	// a zero byte ends the text and can never be passed through
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.byte_present |-> result_q.clean_byte != 8'h00)
		else $error("zero byte passed through");

endmodule
